FILE: sv/tmap_pkg.sv
// ----------------------------------------------------------------------------
// tmap_pkg
// Shared constants, threshold tables and stage types for the tone mapper.
// ----------------------------------------------------------------------------
package tmap_pkg;

   localparam int unsigned DataW    = 24;
   localparam int unsigned CodeW    = 8;
   localparam int unsigned LevelW   = 16;
   localparam int unsigned NumerW   = 42;
   localparam int unsigned DivisorW = 26;
   localparam int unsigned DivSteps = 16;
   localparam int unsigned EncSteps = 8;
   localparam int unsigned LinCodes = 10;
   localparam int unsigned LinMaxT  = 205;

   // multiply, saturate, divider set-up, divider, encoder
   localparam int unsigned ChanLat  = 3 + DivSteps + EncSteps + 2;

   localparam logic [DataW-1:0] GainReset = 24'h010000;
   localparam logic [CodeW-1:0] AlphaCode = 8'hFF;

   typedef logic [16:0]    thr_type;
   typedef thr_type [255:0] thr_tab_type;
   typedef logic [7:0]     lthr_type;
   typedef lthr_type [LinCodes:1] lthr_tab_type;

   // smallest level whose power-segment encoding reaches code k
   function automatic thr_tab_type pow_thresholds();
      thr_tab_type t;
      real         c;
      real         r;
      int          i;
      t = '0;
      for (int k = 1; k < 256; k++) begin
         c = real'(200 * k + 2705) / 53805.0;
         r = 65536.0 * $exp(2.4 * $ln(c));
         i = $rtoi(r);
         if (real'(i) < r) begin
            i = i + 1;
         end
         t[k] = thr_type'(i);
      end
      return t;
   endfunction

   // smallest level whose linear-segment encoding reaches code j
   function automatic lthr_tab_type lin_thresholds();
      lthr_tab_type t;
      longint       a;
      for (int j = 1; j <= LinCodes; j++) begin
         a    = longint'(j) * 64'd13107200 - 64'd6553600;
         t[j] = lthr_type'((a + 64'd658919) / 64'd658920);
      end
      return t;
   endfunction

   localparam thr_tab_type  PowThr = pow_thresholds();
   localparam lthr_tab_type LinThr = lin_thresholds();

endpackage

FILE: sv/tmap_div.sv
// ----------------------------------------------------------------------------
// tmap_div
// Reinhard compression v/(1+v), rounded, as a one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module tmap_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [tmap_pkg::DataW-1:0]       v,
   output logic [tmap_pkg::LevelW-1:0]      level
);

   logic [tmap_pkg::NumerW-1:0]   rem_ff [0:tmap_pkg::DivSteps];
   logic [tmap_pkg::DivisorW-1:0] d_ff   [0:tmap_pkg::DivSteps];
   logic [tmap_pkg::LevelW-1:0]   q_ff   [0:tmap_pkg::DivSteps];

   logic [tmap_pkg::DivisorW-2:0] den;
   assign den = {1'b0, v} + 25'h010000;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {1'b0, v, 17'b0} + tmap_pkg::NumerW'(den);
         d_ff[0]   <= {den, 1'b0};
         q_ff[0]   <= '0;
      end
   end

   for (genvar s = 0; s < tmap_pkg::DivSteps; s++) begin : g_step
      localparam int unsigned Bit = tmap_pkg::DivSteps - 1 - s;
      logic [tmap_pkg::NumerW-1:0] sub;
      logic [tmap_pkg::NumerW-1:0] rem_in;
      logic [tmap_pkg::LevelW-1:0] q_in;
      always_comb begin
         sub    = tmap_pkg::NumerW'(d_ff[s]) << Bit;
         rem_in = rem_ff[s];
         q_in   = q_ff[s];
         if (rem_ff[s] >= sub) begin
            rem_in   = rem_ff[s] - sub;
            q_in[Bit] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            d_ff[s+1]   <= d_ff[s];
            q_ff[s+1]   <= q_in;
         end
      end
   end

   assign level = q_ff[tmap_pkg::DivSteps];

endmodule

FILE: sv/tmap_enc.sv
// ----------------------------------------------------------------------------
// tmap_enc
// sRGB encoding of a Q0.16 level: linear segment compares, power segment
// binary search over the threshold table, one code bit per stage.
// ----------------------------------------------------------------------------
module tmap_enc (
   input  logic                         clock,
   input  logic                         en,
   input  logic [tmap_pkg::LevelW-1:0]  level,
   output logic [tmap_pkg::CodeW-1:0]   code
);

   logic [tmap_pkg::LevelW-1:0] t_ff    [0:tmap_pkg::EncSteps];
   logic                        lin_ff  [0:tmap_pkg::EncSteps];
   logic [3:0]                  lcode_ff[0:tmap_pkg::EncSteps];
   logic [tmap_pkg::CodeW-1:0]  pcode_ff[0:tmap_pkg::EncSteps];
   logic [tmap_pkg::CodeW-1:0]  code_ff;

   logic [3:0] lcode_in;
   always_comb begin
      lcode_in = '0;
      for (int j = 1; j <= tmap_pkg::LinCodes; j++) begin
         if (level >= tmap_pkg::LevelW'(tmap_pkg::LinThr[j])) begin
            lcode_in = lcode_in + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0]     <= level;
         lin_ff[0]   <= (level <= tmap_pkg::LevelW'(tmap_pkg::LinMaxT));
         lcode_ff[0] <= lcode_in;
         pcode_ff[0] <= '0;
      end
   end

   for (genvar s = 0; s < tmap_pkg::EncSteps; s++) begin : g_step
      localparam int unsigned Bit = tmap_pkg::EncSteps - 1 - s;
      logic [tmap_pkg::CodeW-1:0] cand;
      logic [tmap_pkg::CodeW-1:0] pcode_in;
      always_comb begin
         cand = pcode_ff[s];
         cand[Bit] = 1'b1;
         pcode_in = pcode_ff[s];
         if ({1'b0, t_ff[s]} >= tmap_pkg::PowThr[cand]) begin
            pcode_in = cand;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            t_ff[s+1]     <= t_ff[s];
            lin_ff[s+1]   <= lin_ff[s];
            lcode_ff[s+1] <= lcode_ff[s];
            pcode_ff[s+1] <= pcode_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= lin_ff[tmap_pkg::EncSteps]
                    ? tmap_pkg::CodeW'(lcode_ff[tmap_pkg::EncSteps])
                    : pcode_ff[tmap_pkg::EncSteps];
      end
   end

   assign code = code_ff;

endmodule

FILE: sv/tmap_chan.sv
// ----------------------------------------------------------------------------
// tmap_chan
// One colour channel: exposure gain, clamp and saturate, Reinhard, sRGB code.
// ----------------------------------------------------------------------------
module tmap_chan (
   input  logic                        clock,
   input  logic                        en,
   input  logic [tmap_pkg::DataW-1:0]  radiance,
   input  logic [tmap_pkg::DataW-1:0]  gain,
   output logic [tmap_pkg::CodeW-1:0]  code
);

   logic [46:0]                  prod_ff;
   logic [46:0]                  prod_in;
   logic [tmap_pkg::DataW-1:0]   v_ff;
   logic [tmap_pkg::DataW-1:0]   v_in;
   logic [tmap_pkg::LevelW-1:0]  level;
   logic [22:0]                  mag;

   // negative radiance clamps to zero
   assign mag     = radiance[23] ? '0 : radiance[22:0];
   assign prod_in = mag * gain;
   assign v_in    = (|prod_ff[46:40]) ? '1 : prod_ff[39:16];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         v_ff    <= v_in;
      end
   end

   tmap_div u_div (
      .clock (clock),
      .en    (en),
      .v     (v_ff),
      .level (level)
   );

   tmap_enc u_enc (
      .clock (clock),
      .en    (en),
      .level (level),
      .code  (code)
   );

endmodule

FILE: sv/hdr_tonemap_srgb8_pack.sv
// ----------------------------------------------------------------------------
// hdr_tonemap_srgb8_pack
// Throughput: one pixel per cycle; the whole pipeline holds on output stall.
// Depth is set by the 16-stage Reinhard divider and 8-stage sRGB search.
// Reset clears the valid bits and loads exposure gain 1.0.
// ----------------------------------------------------------------------------
module hdr_tonemap_srgb8_pack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // red_in[23:0], green_in[47:24], blue_in[71:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // packed_pixel[31:0]
   input  logic        csr_wen,
   input  logic [23:0] csr_wdata
);

   logic [tmap_pkg::DataW-1:0]   gain_ff;
   logic [tmap_pkg::ChanLat-1:0] valid_ff;
   logic [tmap_pkg::ChanLat-1:0] valid_in;
   logic                         adv;
   logic [tmap_pkg::CodeW-1:0]   red_code;
   logic [tmap_pkg::CodeW-1:0]   green_code;
   logic [tmap_pkg::CodeW-1:0]   blue_code;

   assign adv        = !valid_ff[tmap_pkg::ChanLat-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[tmap_pkg::ChanLat-1];
   assign valid_in   = {valid_ff[tmap_pkg::ChanLat-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= tmap_pkg::GainReset;
         valid_ff <= '0;
      end else begin
         if (csr_wen) begin
            gain_ff <= csr_wdata;
         end
         if (adv) begin
            valid_ff <= valid_in;
         end
      end
   end

   tmap_chan u_red (
      .clock    (clock),
      .en       (adv),
      .radiance (req_tdata[23:0]),
      .gain     (gain_ff),
      .code     (red_code)
   );

   tmap_chan u_green (
      .clock    (clock),
      .en       (adv),
      .radiance (req_tdata[47:24]),
      .gain     (gain_ff),
      .code     (green_code)
   );

   tmap_chan u_blue (
      .clock    (clock),
      .en       (adv),
      .radiance (req_tdata[71:48]),
      .gain     (gain_ff),
      .code     (blue_code)
   );

   assign rsp_tdata = {tmap_pkg::AlphaCode, blue_code, green_code, red_code};

endmodule
